// File: rtl/assert_macros.svh
// Assertion macros used by the keyboard matrix emulator RTL (kme_matrix).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/kme_pkg.sv
// Types, constants and key map table for the keyboard matrix emulator.
`default_nettype none
package kme_pkg;

    localparam int COLUMN_COUNT = 8;
    localparam int MAP_ENTRIES  = 128;
    localparam int COL_IDX_W    = $clog2(COLUMN_COUNT);
    localparam int CODE_W       = $clog2(MAP_ENTRIES);
    localparam int ROW_W        = 8;
    localparam int MAP_COL_W    = 4;
    localparam int MAP_ENTRY_W  = MAP_COL_W + 1 + ROW_W;

    localparam logic [ROW_W-1:0]     SHIFT_ROW_BIT = 8'h10;
    localparam logic [COL_IDX_W-1:0] SHIFT_COLUMN  = COL_IDX_W'(COLUMN_COUNT - 1);
    localparam logic [ROW_W-1:0]     ALL_ROWS      = 8'hff;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef struct packed {
        logic              valid;
        action_t           action;
        logic [CODE_W-1:0] key_code;
        logic [ROW_W-1:0]  row_select;
    } kme_item_t;

    typedef struct packed {
        logic [MAP_COL_W-1:0] column;
        logic                 shifted;
        logic [ROW_W-1:0]     rows;
    } map_entry_t;

    typedef logic [COLUMN_COUNT-1:0][ROW_W-1:0] matrix_t;

    function automatic logic [MAP_ENTRY_W-1:0] mk(input int c, input int m);
        mk = {MAP_COL_W'(c), 1'b0, ROW_W'(m)};
    endfunction

    function automatic logic [MAP_ENTRY_W-1:0] mks(input int c, input int m);
        mks = {MAP_COL_W'(c), 1'b1, ROW_W'(m)};
    endfunction

    localparam logic [MAP_ENTRY_W-1:0] Z = '0;

    localparam logic [MAP_ENTRY_W-1:0] KEY_MAP [0:MAP_ENTRIES-1] = '{
        Z, Z, Z, Z, Z, Z, Z, Z,
        mk(1,2), mk(8,4), Z, Z, Z, mk(1,8), Z, Z,
        Z, Z, Z, Z, Z, Z, Z, Z,
        Z, Z, Z, mk(1,2), Z, Z, Z, Z,
        mk(7,16), mks(8,4), mks(8,1), mks(7,1), mks(6,4), mks(6,1), mks(5,1), mks(4,4),
        mks(4,1), mks(3,1), mks(1,4), mks(1,1), mk(2,32), mk(2,1), mk(1,32), mk(2,2),
        mk(2,4), mk(8,4), mk(8,1), mk(7,1), mk(6,4), mk(6,1), mk(5,1), mk(4,4),
        mk(4,1), mk(3,1), mk(1,4), mk(1,16), mks(2,32), mk(1,1), mks(1,32), mks(2,4),
        mks(1,16), mks(7,32), mks(4,32), mks(5,16), mks(6,16), mks(7,2), mks(5,32), mks(5,4),
        mks(4,16), mks(4,2), mks(3,32), mks(3,4), mks(2,16), mks(3,8), mks(3,16), mks(3,2),
        mks(2,8), mks(8,8), mks(6,8), mks(7,4), mks(6,2), mks(4,8), mks(5,8), mks(8,2),
        mks(6,32), mks(5,2), mks(7,8), Z, Z, Z, Z, Z,
        mk(1,2), mk(7,32), mk(4,32), mk(5,16), mk(6,16), mk(7,2), mk(5,32), mk(5,4),
        mk(4,16), mk(4,2), mk(3,32), mk(3,4), mk(2,16), mk(3,8), mk(3,16), mk(3,2),
        mk(2,8), mk(8,8), mk(6,8), mk(7,4), mk(6,2), mk(4,8), mk(5,8), mk(8,2),
        mk(6,32), mk(5,2), mk(7,8), Z, Z, Z, Z, mk(1,2)
    };

endpackage
`default_nettype wire

// File: rtl/kme_input_stage.sv
// Input register capturing one command transaction per cycle while accept is high.
`default_nettype none
module kme_input_stage
    import kme_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              accept,
    input  wire logic [1:0]        action,
    input  wire logic [CODE_W-1:0] key_code,
    input  wire logic [ROW_W-1:0]  row_select,
    output kme_item_t              item
);

    logic              valid_reg;
    action_t           action_reg;
    logic [CODE_W-1:0] key_code_reg;
    logic [ROW_W-1:0]  row_select_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && accept)
        begin
            action_reg     <= action_t'(action);
            key_code_reg   <= key_code;
            row_select_reg <= row_select;
        end
    end

    assign item = '{valid: valid_reg, action: action_reg,
                    key_code: key_code_reg, row_select: row_select_reg};

endmodule
`default_nettype wire

// File: rtl/kme_matrix.sv
// Key matrix state, key event update, port read select and result register.
`default_nettype none
`include "assert_macros.svh"
module kme_matrix
    import kme_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  kme_item_t              item,
    output logic                   done,
    output logic [ROW_W-1:0]       read_data,
    output logic [CODE_W-1:0]      echoed_key
);

    matrix_t           columns_reg;
    matrix_t           columns_next;
    logic              any_key_reg;
    logic              any_key_next;
    logic              done_reg;
    logic [ROW_W-1:0]  read_data_reg;
    logic [ROW_W-1:0]  read_data_next;
    logic [CODE_W-1:0] echoed_key_reg;
    logic [CODE_W-1:0] echoed_key_next;

    map_entry_t           entry;
    logic                 mapped;
    logic [COL_IDX_W-1:0] col_idx;
    logic [ROW_W-1:0]     active;
    logic [ROW_W-1:0]     sel_data;

    assign entry   = map_entry_t'(KEY_MAP[item.key_code]);
    assign mapped  = (entry.column != '0) &&
                     (entry.column <= MAP_COL_W'(COLUMN_COUNT));
    assign col_idx = COL_IDX_W'(entry.column - MAP_COL_W'(1));
    assign active  = ~item.row_select;

    always_comb
    begin
        sel_data = ALL_ROWS;
        for (int b = 0; b < COLUMN_COUNT; b++)
        begin
            if (active[b])
            begin
                sel_data = ~columns_reg[b];
            end
        end
    end

    always_comb
    begin
        columns_next    = columns_reg;
        read_data_next  = '0;
        echoed_key_next = '0;
        if (item.valid)
        begin
            case (item.action)
                ACT_PRESS:
                begin
                    if (mapped)
                    begin
                        for (int i = 0; i < COLUMN_COUNT; i++)
                        begin
                            if (col_idx == COL_IDX_W'(i))
                            begin
                                columns_next[i] = columns_next[i] | entry.rows;
                            end
                        end
                        if (entry.shifted)
                        begin
                            columns_next[SHIFT_COLUMN] =
                                columns_next[SHIFT_COLUMN] | SHIFT_ROW_BIT;
                        end
                        echoed_key_next = item.key_code;
                    end
                end
                ACT_RELEASE:
                begin
                    if (mapped)
                    begin
                        for (int i = 0; i < COLUMN_COUNT; i++)
                        begin
                            if (col_idx == COL_IDX_W'(i))
                            begin
                                columns_next[i] = columns_next[i] & ~entry.rows;
                            end
                        end
                        if (entry.shifted)
                        begin
                            columns_next[SHIFT_COLUMN] =
                                columns_next[SHIFT_COLUMN] & ~SHIFT_ROW_BIT;
                        end
                    end
                end
                ACT_READ:
                begin
                    if (active == ALL_ROWS && any_key_reg)
                    begin
                        read_data_next = '0;
                    end
                    else
                    begin
                        read_data_next = sel_data;
                    end
                end
                default:
                begin
                    read_data_next = '0;
                end
            endcase
        end
    end

    assign any_key_next = |columns_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg    <= '0;
            any_key_reg    <= 1'b0;
            done_reg       <= 1'b0;
            read_data_reg  <= '0;
            echoed_key_reg <= '0;
        end
        else
        begin
            columns_reg <= columns_next;
            any_key_reg <= any_key_next;
            done_reg    <= item.valid;
            if (item.valid)
            begin
                read_data_reg  <= read_data_next;
                echoed_key_reg <= echoed_key_next;
            end
        end
    end

    assign done       = done_reg;
    assign read_data  = read_data_reg;
    assign echoed_key = echoed_key_reg;

    `ASSERT_PROP(a_done_follows, clk, rst_n, item.valid |=> done_reg, "result strobe missing")
    `ASSERT_PROP(a_no_spurious, clk, rst_n, !item.valid |=> !done_reg, "unexpected strobe")
    `ASSERT_PROP(a_any_key, clk, rst_n, any_key_reg == (|columns_reg), "any-key flag out of step")
    `ASSERT_NEVER(a_one_kind, clk, rst_n, (read_data_reg != '0) && (echoed_key_reg != '0),
        "result carries both read data and echoed key")
    `ASSERT_PROP(a_hold, clk, rst_n,
        !(item.valid && (item.action == ACT_PRESS || item.action == ACT_RELEASE))
        |=> $stable(columns_reg), "matrix changed without a key event")

endmodule
`default_nettype wire

// File: rtl/keyboard_matrix_emulator_unit.sv
// Top level of the keyboard matrix emulator.
// An accepted transaction goes through the input register and the result register (done high).
// Throughput: one transaction per cycle; busy is tied low.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (rst_n, async, active low) clears all column bits, the any-key flag and the strobe.
`default_nettype none
module keyboard_matrix_emulator_unit
    import kme_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        action,
    input  wire logic [CODE_W-1:0] key_code,
    input  wire logic [ROW_W-1:0]  row_select,
    output logic                   done,
    output logic [ROW_W-1:0]       read_data,
    output logic [CODE_W-1:0]      echoed_key
);

    kme_item_t item;

    assign busy = 1'b0;

    kme_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .accept     (!busy),
        .action     (action),
        .key_code   (key_code),
        .row_select (row_select),
        .item       (item)
    );

    kme_matrix u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .done       (done),
        .read_data  (read_data),
        .echoed_key (echoed_key)
    );

endmodule
`default_nettype wire

// File: test/keyboard_matrix_checker.sv
// Checker for the keyboard matrix emulator: predicts each result and compares it.
module keyboard_matrix_checker
    import kme_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [1:0]        action,
    input  wire logic [CODE_W-1:0] key_code,
    input  wire logic [ROW_W-1:0]  row_select,
    input  wire logic              done,
    input  wire logic [ROW_W-1:0]  read_data,
    input  wire logic [CODE_W-1:0] echoed_key,
    output int                     mismatch_count,
    output int                     responses_owed,
    output int                     responses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ROW_W-1:0] SHIFT_ROW = 8'h10;

    typedef struct packed {
        logic [ROW_W-1:0]  data;
        logic [CODE_W-1:0] key;
    } port_response_t;

    port_response_t   pending_responses[$];
    logic [12:0]      key_code_map [0:MAP_ENTRIES-1];
    logic [ROW_W-1:0] column_state [0:COLUMN_COUNT-1];
    logic             any_key_held;

    // map word: column in 12:9, shift flag in 8, row mask in 7:0
    function automatic logic [12:0] kp(input int col, input int rows);
        kp = {col[3:0], 1'b0, rows[7:0]};
    endfunction

    function automatic logic [12:0] ks(input int col, input int rows);
        ks = {col[3:0], 1'b1, rows[7:0]};
    endfunction

    initial
    begin
        key_code_map = '{
            0, 0, 0, 0, 0, 0, 0, 0,
            kp(1,2), kp(8,4), 0, 0, 0, kp(1,8), 0, 0,
            0, 0, 0, 0, 0, 0, 0, 0,
            0, 0, 0, kp(1,2), 0, 0, 0, 0,
            kp(7,16), ks(8,4), ks(8,1), ks(7,1), ks(6,4), ks(6,1), ks(5,1), ks(4,4),
            ks(4,1), ks(3,1), ks(1,4), ks(1,1), kp(2,32), kp(2,1), kp(1,32), kp(2,2),
            kp(2,4), kp(8,4), kp(8,1), kp(7,1), kp(6,4), kp(6,1), kp(5,1), kp(4,4),
            kp(4,1), kp(3,1), kp(1,4), kp(1,16), ks(2,32), kp(1,1), ks(1,32), ks(2,4),
            ks(1,16), ks(7,32), ks(4,32), ks(5,16), ks(6,16), ks(7,2), ks(5,32), ks(5,4),
            ks(4,16), ks(4,2), ks(3,32), ks(3,4), ks(2,16), ks(3,8), ks(3,16), ks(3,2),
            ks(2,8), ks(8,8), ks(6,8), ks(7,4), ks(6,2), ks(4,8), ks(5,8), ks(8,2),
            ks(6,32), ks(5,2), ks(7,8), 0, 0, 0, 0, 0,
            kp(1,2), kp(7,32), kp(4,32), kp(5,16), kp(6,16), kp(7,2), kp(5,32), kp(5,4),
            kp(4,16), kp(4,2), kp(3,32), kp(3,4), kp(2,16), kp(3,8), kp(3,16), kp(3,2),
            kp(2,8), kp(8,8), kp(6,8), kp(7,4), kp(6,2), kp(4,8), kp(5,8), kp(8,2),
            kp(6,32), kp(5,2), kp(7,8), 0, 0, 0, 0, kp(1,2)
        };
    end

    task automatic emulate_transaction(
        input  logic [1:0]        act,
        input  logic [CODE_W-1:0] code,
        input  logic [ROW_W-1:0]  sel,
        output port_response_t    resp
    );
        logic [12:0]          entry;
        logic [3:0]           col;
        logic [COL_IDX_W-1:0] idx;
        logic [ROW_W-1:0]     active;
        logic                 found;
        resp   = '0;
        entry  = key_code_map[code];
        col    = entry[12:9];
        idx    = COL_IDX_W'(col - 4'd1);
        active = ~sel;
        found  = 1'b0;
        case (act)
            ACT_PRESS, ACT_RELEASE:
            begin
                if (col != 4'd0 && col <= 4'(COLUMN_COUNT))
                begin
                    if (act == ACT_PRESS)
                    begin
                        column_state[idx] = column_state[idx] | entry[7:0];
                        if (entry[8])
                            column_state[COLUMN_COUNT - 1] =
                                column_state[COLUMN_COUNT - 1] | SHIFT_ROW;
                        resp.key = code;
                    end
                    else
                    begin
                        column_state[idx] = column_state[idx] & ~entry[7:0];
                        // shift goes away even if another shifted key is still down
                        if (entry[8])
                            column_state[COLUMN_COUNT - 1] =
                                column_state[COLUMN_COUNT - 1] & ~SHIFT_ROW;
                    end
                end
                any_key_held = 1'b0;
                for (int c = 0; c < COLUMN_COUNT; c++)
                    any_key_held = any_key_held | (|column_state[c]);
            end
            ACT_READ:
            begin
                if (active == 8'hff && any_key_held)
                    resp.data = 8'h00;
                else
                begin
                    resp.data = 8'hff;
                    for (int b = COLUMN_COUNT - 1; b >= 0; b--)
                    begin
                        if (!found && active[b])
                        begin
                            resp.data = ~column_state[b];
                            found     = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic void flag_mismatch(input string field, input int expv, input int actv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t",
                     field, expv, actv, $realtime);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        port_response_t predicted;
        port_response_t oldest;
        if (!rst_n)
        begin
            pending_responses.delete();
            for (int c = 0; c < COLUMN_COUNT; c++)
                column_state[c] = '0;
            any_key_held   = 1'b0;
            mismatch_count = 0;
            responses_owed = 0;
            responses_seen = 0;
        end
        else
        begin
            if (done)
            begin
                responses_seen++;
                if (pending_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: result data 0x%0h key 0x%0h with none pending",
                                 read_data, echoed_key);
                end
                else
                begin
                    oldest = pending_responses.pop_front();
                    if (read_data !== oldest.data)
                        flag_mismatch("read_data", int'(oldest.data), int'(read_data));
                    if (echoed_key !== oldest.key)
                        flag_mismatch("echoed_key", int'(oldest.key), int'(echoed_key));
                end
            end
            if (start && !busy)
            begin
                emulate_transaction(action, key_code, row_select, predicted);
                pending_responses.push_back(predicted);
            end
            responses_owed = pending_responses.size();
        end
    end

endmodule

// File: test/tb_keyboard_matrix_emulator_unit.sv
// Testbench top: drives keyboard matrix emulator transactions and reports the verdict.
module tb_keyboard_matrix_emulator_unit import kme_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 1000;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic [1:0]        action     = ACT_NONE;
    logic [CODE_W-1:0] key_code   = '0;
    logic [ROW_W-1:0]  row_select = '0;
    logic              busy;
    logic              done;
    logic [ROW_W-1:0]  read_data;
    logic [CODE_W-1:0] echoed_key;
    int                mismatches;
    int                owed;
    int                compared;

    int                stall_cycles = 0;
    bit                no_gaps      = 1'b0;
    int                n_press      = 0;
    int                n_release    = 0;
    int                n_read       = 0;
    int                n_unused     = 0;
    logic [CODE_W-1:0] held_keys[$];

    always #10 clk = ~clk;

    keyboard_matrix_emulator_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .key_code   (key_code),
        .row_select (row_select),
        .done       (done),
        .read_data  (read_data),
        .echoed_key (echoed_key)
    );

    keyboard_matrix_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .key_code       (key_code),
        .row_select     (row_select),
        .done           (done),
        .read_data      (read_data),
        .echoed_key     (echoed_key),
        .mismatch_count (mismatches),
        .responses_owed (owed),
        .responses_seen (compared)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic issue(input action_t act, input logic [CODE_W-1:0] code,
                         input logic [ROW_W-1:0] sel);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        key_code   <= code;
        row_select <= sel;
        do
            @(posedge clk);
        while (busy);
        case (act)
            ACT_PRESS:   n_press++;
            ACT_RELEASE: n_release++;
            ACT_READ:    n_read++;
            default:     n_unused++;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (owed != 0);
        @(posedge clk);
    endtask

    function automatic logic [CODE_W-1:0] mapped_code();
        logic [CODE_W-1:0] extras [5];
        extras = '{7'd8, 7'd9, 7'd13, 7'd27, 7'd127};
        case ($urandom_range(0, 3))
            0, 1:    mapped_code = CODE_W'($urandom_range(32, 90));
            2:       mapped_code = CODE_W'($urandom_range(96, 122));
            default: mapped_code = extras[$urandom_range(0, 4)];
        endcase
    endfunction

    task automatic random_transaction();
        int                pick;
        int                idx;
        int                b;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  low_bits;
        pick = $urandom_range(0, 99);
        if (pick < 35 && held_keys.size() >= 10)
            pick = 40;
        b        = $urandom_range(0, 7);
        low_bits = ROW_W'($urandom);
        if (pick < 35)
        begin
            code = mapped_code();
            held_keys.push_back(code);
            issue(ACT_PRESS, code, ROW_W'($urandom));
        end
        else if (pick < 55 && held_keys.size() > 0)
        begin
            idx  = $urandom_range(0, held_keys.size() - 1);
            code = held_keys[idx];
            held_keys.delete(idx);
            issue(ACT_RELEASE, code, ROW_W'($urandom));
        end
        else if (pick < 60)
            issue(ACT_RELEASE, CODE_W'($urandom), ROW_W'($urandom));
        else if (pick < 65)
            issue(ACT_PRESS, CODE_W'($urandom), ROW_W'($urandom));
        else if (pick < 85)
            // one active-low select bit decides the column, lower bits are don't-care
            issue(ACT_READ, CODE_W'($urandom),
                  ~((8'h01 << b) | (low_bits & ((8'h01 << b) - 8'h01))));
        else if (pick < 93)
            issue(ACT_READ, CODE_W'($urandom), ROW_W'($urandom));
        else if (pick < 96)
            issue(ACT_READ, CODE_W'($urandom), 8'h00);
        else if (pick < 98)
            issue(ACT_READ, CODE_W'($urandom), 8'hff);
        else
            issue(ACT_NONE, CODE_W'($urandom), ROW_W'($urandom));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(ACT_READ, 7'd0, 8'h00);
        issue(ACT_READ, 7'd127, 8'hff);
        issue(ACT_PRESS, 7'd0, 8'hff);
        issue(ACT_RELEASE, 7'd0, 8'h00);
        issue(ACT_PRESS, 7'd127, 8'h00);
        issue(ACT_READ, 7'd0, 8'hfe);
        issue(ACT_READ, 7'd0, 8'h00);
        issue(ACT_PRESS, 7'd65, 8'h00);
        issue(ACT_PRESS, 7'd66, 8'h00);
        issue(ACT_READ, 7'd0, 8'h7f);
        issue(ACT_RELEASE, 7'd65, 8'h00);
        issue(ACT_READ, 7'd0, 8'h7f);
        issue(ACT_READ, 7'd0, 8'hbf);
        issue(ACT_PRESS, 7'd9, 8'h00);
        issue(ACT_READ, 7'd0, 8'h7f);
        issue(ACT_NONE, 7'd127, 8'h00);
        issue(ACT_RELEASE, 7'd66, 8'h00);
        issue(ACT_RELEASE, 7'd127, 8'h00);
        issue(ACT_RELEASE, 7'd9, 8'h00);
        issue(ACT_READ, 7'd0, 8'h00);
        issue(ACT_PRESS, 7'd91, 8'h00);
        issue(ACT_READ, 7'd0, 8'h55);
        issue(ACT_PRESS, 7'd32, 8'h00);
        issue(ACT_READ, 7'd0, 8'h80);
        issue(ACT_RELEASE, 7'd32, 8'h00);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if (i % 300 == 150)
                drain();
            random_transaction();
        end
        drain();
        repeat (6) @(posedge clk);

        $display("covered %0d presses, %0d releases, %0d port reads, %0d unused-action ops",
                 n_press, n_release, n_read, n_unused);
        $display("compared %0d results, %0d mismatches, %0d still pending",
                 compared, mismatches, owed);
        if (mismatches == 0 && owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
